// File: rtl/scfbc_pkg.sv
// ----------------------------------------------------------------------------
// scfbc_pkg
// Shared codes, widths and controller/datapath interface types for the
// size-class free block cache.
// ----------------------------------------------------------------------------
package scfbc_pkg;

    // fixed field widths
    localparam int DVW      = 32;   // divider dividend / wide arithmetic
    localparam int DSW      = 17;   // divider divisor (class capacity)
    localparam int KW       = 7;    // pop count
    localparam int MAX_POPS = 64;   // most handles popped by one transaction

    // operation modes
    localparam logic [2:0] MODE_TAKE    = 3'd0;
    localparam logic [2:0] MODE_STORE   = 3'd1;
    localparam logic [2:0] MODE_REFILL  = 3'd2;
    localparam logic [2:0] MODE_EXTRACT = 3'd3;
    localparam logic [2:0] MODE_EVICT   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_BAD_CLASS = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_KSET,
        OP_MUL,
        OP_DIV_REFILL,
        OP_DIV_EVICT,
        OP_AMT_SUM,
        OP_AMT_PROD,
        OP_AMT_QUOT,
        OP_APPLY,
        OP_STORE,
        OP_POP_RD,
        OP_POP_OUT,
        OP_EMIT,
        OP_EMIT_REFILL,
        OP_SCAN_NEXT,
        OP_SCAN_TAKE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       whole;      // whole-class eviction in progress
        logic [1:0] status;     // status for a single status result
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       mode_bad;
        logic       class_bad;
        logic       cnt_zero;
        logic       cnt_full;
        logic       over_limit;
        logic       over_budget;
        logic       maxc_zero;
        logic       cap_zero;
        logic       scan_hit;
        logic       scan_last;
        logic       k_is_cnt;
        logic       pop_last;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

// File: rtl/scfbc_ram.sv
// ----------------------------------------------------------------------------
// scfbc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scfbc_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                          i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                          o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/scfbc_div.sv
// ----------------------------------------------------------------------------
// scfbc_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scfbc_div
    import scfbc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [DSW-1:0] i_divisor,
    output logic           o_done,
    output logic [DVW-1:0] o_quot
);

    localparam int CNTW = $clog2(DVW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DSW:0]    r_rem;
    logic [DVW-1:0]  r_quot;
    logic [DSW-1:0]  r_div;
    logic [DSW:0]    rem_sh;
    logic            q_bit;

    // trial subtract
    always_comb begin
        rem_sh = {r_rem[DSW-1:0], r_quot[DVW-1]};
        q_bit  = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_quot <= {r_quot[DVW-2:0], q_bit};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(DVW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/scfbc_dp.sv
// ----------------------------------------------------------------------------
// scfbc_dp
// Datapath: captured transaction, per-class counts and byte sums, total byte
// sum, handle stack RAM, divider and the result register.
// ----------------------------------------------------------------------------
module scfbc_dp
    import scfbc_pkg::*;
#(
    parameter int CLASS_COUNT       = 16,
    parameter int CLASS_BLOCK_LIMIT = 32,
    parameter int TOTAL_BYTE_LIMIT  = 65536,
    parameter int REFILL_LIMIT      = 16,
    parameter int STACK_DEPTH       = 64,
    parameter int HANDLE_BITS       = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_class_index,
    input  logic [16:0] i_class_capacity,
    input  logic [31:0] i_handle,
    input  logic [6:0]  i_max_count,
    input  logic [6:0]  i_available_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_handle_out,
    output logic        o_handle_valid,
    output logic [3:0]  o_class_out,
    output logic [6:0]  o_accept_count,
    output logic        o_last,
    output logic [1:0]  o_status
);

    localparam int CIW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int PW  = $clog2(STACK_DEPTH);
    localparam int SW  = PW + 17;
    localparam int TW  = SW + CIW + 1;
    localparam int RD  = CLASS_COUNT * STACK_DEPTH;
    localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
    localparam logic [31:0] HMASK = (HANDLE_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << HANDLE_BITS) - 64'd1);

    // captured transaction
    logic [2:0]     r_mode;
    logic [3:0]     r_cls_in;
    logic [16:0]    r_cap;
    logic [31:0]    r_h;
    logic [6:0]     r_maxc;
    logic [6:0]     r_avail;

    // working registers
    logic [CIW-1:0] r_cls;
    logic [CIW-1:0] r_scan;
    logic [KW-1:0]  r_k;
    logic           r_lastpop;
    logic [DVW-1:0] r_prod;
    logic [DVW-1:0] r_amt;

    // cache state
    logic [CW-1:0]  r_cnt [CLASS_COUNT];
    logic [SW-1:0]  r_sum [CLASS_COUNT];
    logic [TW-1:0]  r_total;

    // result register
    logic           r_ov;
    logic [31:0]    r_oh;
    logic           r_ohv;
    logic [3:0]     r_ocls;
    logic [6:0]     r_oacc;
    logic           r_olast;
    logic [1:0]     r_ost;

    logic [CW-1:0]  cur_cnt;
    logic [SW-1:0]  cur_sum;
    logic [DVW-1:0] cnt_w, sum_w, kx, room_w, bytes_w, lim_w, sub_w, base_w;
    logic [DVW-1:0] div_dividend, quot;
    logic [DSW-1:0] div_divisor;
    logic           div_start, div_done, out_free;
    logic           ram_we, ram_re;
    logic [RAW-1:0] ram_waddr, ram_raddr;
    logic [31:0]    ram_rdata;

    assign cur_cnt  = r_cnt[r_cls];
    assign cur_sum  = r_sum[r_cls];
    assign cnt_w    = DVW'(cur_cnt);
    assign sum_w    = DVW'(cur_sum);
    assign out_free = !r_ov || i_ready;

    // pop count for the current operation
    always_comb begin
        if (i_cmd.whole) begin
            kx = cnt_w;
        end else begin
            case (r_mode)
                MODE_TAKE:    kx = DVW'(1);
                MODE_EXTRACT: kx = (DVW'(r_maxc) < cnt_w) ? DVW'(r_maxc) : cnt_w;
                default:      kx = cnt_w - DVW'(CLASS_BLOCK_LIMIT);
            endcase
        end
        if (kx > DVW'(MAX_POPS)) begin
            kx = DVW'(MAX_POPS);
        end
    end

    // refill answer
    always_comb begin
        room_w  = (cnt_w < DVW'(CLASS_BLOCK_LIMIT)) ? DVW'(CLASS_BLOCK_LIMIT) - cnt_w : '0;
        bytes_w = (DVW'(r_total) < DVW'(TOTAL_BYTE_LIMIT)) ?
                  DVW'(TOTAL_BYTE_LIMIT) - DVW'(r_total) : '0;
        lim_w   = DVW'(REFILL_LIMIT);
        if (DVW'(r_avail) < lim_w) lim_w = DVW'(r_avail);
        if (room_w < lim_w) lim_w = room_w;
        if ((r_cap != '0) && (quot < lim_w)) lim_w = quot;
    end

    // saturated byte amount and stack addressing
    assign sub_w     = (r_amt > sum_w) ? sum_w : r_amt;
    assign base_w    = DVW'(r_cls) * DVW'(STACK_DEPTH);
    assign ram_we    = (i_cmd.op == OP_STORE);
    assign ram_re    = (i_cmd.op == OP_POP_RD);
    assign ram_waddr = RAW'(base_w + cnt_w);
    assign ram_raddr = RAW'(base_w + cnt_w - DVW'(1));

    // divider operands
    assign div_start    = (i_cmd.op == OP_DIV_REFILL) || (i_cmd.op == OP_DIV_EVICT);
    assign div_dividend = (i_cmd.op == OP_DIV_REFILL) ? bytes_w : r_prod;
    assign div_divisor  = (i_cmd.op == OP_DIV_REFILL) ? r_cap : DSW'(cur_cnt);

    scfbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    scfbc_ram #(
        .W     (32),
        .DEPTH (RD)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_h),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // command execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_cnt[i] <= '0;
                r_sum[i] <= '0;
            end
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            // drained result, unless a new one is loaded this cycle
            if (r_ov && i_ready && (i_cmd.op != OP_POP_OUT) && (i_cmd.op != OP_EMIT) &&
                (i_cmd.op != OP_EMIT_REFILL)) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_mode   <= i_mode;
                    r_cls_in <= i_class_index;
                    r_cap    <= i_class_capacity;
                    r_h      <= i_handle & HMASK;
                    r_maxc   <= i_max_count;
                    r_avail  <= i_available_count;
                    r_cls    <= CIW'(i_class_index);
                    r_scan   <= '0;
                end
                OP_KSET:      r_k    <= KW'(kx);
                OP_MUL:       r_prod <= i_cmd.whole ? sum_w * DVW'(r_k)
                                                    : DVW'(r_k) * DVW'(r_cap);
                OP_AMT_SUM:   r_amt  <= sum_w;
                OP_AMT_PROD:  r_amt  <= r_prod;
                OP_AMT_QUOT:  r_amt  <= quot;
                OP_APPLY: begin
                    r_sum[r_cls] <= cur_sum - SW'(sub_w);
                    r_total      <= (DVW'(r_total) < sub_w) ? '0 : r_total - TW'(sub_w);
                end
                OP_STORE: begin
                    r_cnt[r_cls] <= cur_cnt + 1'b1;
                    r_sum[r_cls] <= cur_sum + SW'(r_cap);
                    r_total      <= r_total + TW'(r_cap);
                end
                OP_POP_RD: begin
                    r_cnt[r_cls] <= cur_cnt - 1'b1;
                    r_k          <= r_k - 1'b1;
                    r_lastpop    <= (r_k == KW'(1));
                end
                OP_POP_OUT: begin
                    r_ov    <= 1'b1;
                    r_oh    <= ram_rdata;
                    r_ohv   <= 1'b1;
                    r_ocls  <= 4'(r_cls);
                    r_oacc  <= '0;
                    r_olast <= r_lastpop;
                    r_ost   <= ST_OK;
                end
                OP_EMIT: begin
                    r_ov    <= 1'b1;
                    r_oh    <= '0;
                    r_ohv   <= 1'b0;
                    r_ocls  <= r_cls_in;
                    r_oacc  <= '0;
                    r_olast <= 1'b1;
                    r_ost   <= i_cmd.status;
                end
                OP_EMIT_REFILL: begin
                    r_ov    <= 1'b1;
                    r_oh    <= '0;
                    r_ohv   <= 1'b0;
                    r_ocls  <= r_cls_in;
                    r_oacc  <= 7'(lim_w);
                    r_olast <= 1'b1;
                    r_ost   <= (lim_w == '0) ? ST_EMPTY : ST_OK;
                end
                OP_SCAN_NEXT: r_scan <= r_scan + 1'b1;
                OP_SCAN_TAKE: r_cls  <= r_scan;
                default: ;
            endcase
        end
    end

    // status to the controller
    always_comb begin
        o_sts.mode        = r_mode;
        o_sts.mode_bad    = (r_mode > MODE_EVICT);
        o_sts.class_bad   = (32'(r_cls_in) >= CLASS_COUNT);
        o_sts.cnt_zero    = (cur_cnt == '0);
        o_sts.cnt_full    = (cnt_w >= DVW'(STACK_DEPTH));
        o_sts.over_limit  = (cnt_w > DVW'(CLASS_BLOCK_LIMIT));
        o_sts.over_budget = (DVW'(r_total) > DVW'(TOTAL_BYTE_LIMIT));
        o_sts.maxc_zero   = (r_maxc == '0);
        o_sts.cap_zero    = (r_cap == '0);
        o_sts.scan_hit    = (r_cnt[r_scan] != '0);
        o_sts.scan_last   = (r_scan == CIW'(CLASS_COUNT - 1));
        o_sts.k_is_cnt    = (DVW'(r_k) == cnt_w);
        o_sts.pop_last    = r_lastpop;
        o_sts.div_done    = div_done;
        o_sts.out_free    = out_free;
    end

    assign o_valid        = r_ov;
    assign o_handle_out   = r_oh;
    assign o_handle_valid = r_ohv;
    assign o_class_out    = r_ocls;
    assign o_accept_count = r_oacc;
    assign o_last         = r_olast;
    assign o_status       = r_ost;

endmodule

// File: rtl/scfbc_ctrl.sv
// ----------------------------------------------------------------------------
// scfbc_ctrl
// Controller: decodes each transaction and sequences the datapath through
// sizing, byte accounting, pops and result emission.
// ----------------------------------------------------------------------------
module scfbc_ctrl
    import scfbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_SCAN,
        S_KSETW,
        S_MUL,
        S_AMT,
        S_EDIV,
        S_APPLY,
        S_POP_RD,
        S_POP_OUT,
        S_RDIV,
        S_REFILL_OUT,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic       r_whole, n_whole;
    logic [1:0] r_status, n_status;
    t_op        op;

    always_comb begin
        n_state  = r_state;
        n_whole  = r_whole;
        n_status = r_status;
        op       = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    op      = OP_LOAD;
                    n_whole = 1'b0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_EMIT;
                if (i_sts.mode_bad) begin
                    n_status = ST_EMPTY;
                end else if (i_sts.class_bad) begin
                    n_status = ST_BAD_CLASS;
                end else begin
                    case (i_sts.mode)
                        MODE_TAKE: begin
                            n_status = ST_EMPTY;
                            if (!i_sts.cnt_zero) begin
                                op      = OP_KSET;
                                n_state = S_MUL;
                            end
                        end
                        MODE_STORE: begin
                            if (i_sts.cnt_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                op       = OP_STORE;
                                n_status = ST_OK;
                            end
                        end
                        MODE_REFILL: begin
                            if (i_sts.cap_zero) begin
                                n_state = S_REFILL_OUT;
                            end else begin
                                op      = OP_DIV_REFILL;
                                n_state = S_RDIV;
                            end
                        end
                        MODE_EXTRACT: begin
                            n_status = ST_EMPTY;
                            if (!i_sts.maxc_zero && !i_sts.cnt_zero) begin
                                op      = OP_KSET;
                                n_state = S_MUL;
                            end
                        end
                        default: begin
                            // eviction: excess first, then whole class
                            n_status = ST_EMPTY;
                            if (i_sts.over_limit) begin
                                op      = OP_KSET;
                                n_state = S_MUL;
                            end else if (i_sts.over_budget) begin
                                if (!i_sts.cnt_zero) begin
                                    n_whole = 1'b1;
                                    op      = OP_KSET;
                                    n_state = S_MUL;
                                end else begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                    endcase
                end
            end
            // first non-empty class, one per cycle
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    op      = OP_SCAN_TAKE;
                    n_whole = 1'b1;
                    n_state = S_KSETW;
                end else if (i_sts.scan_last) begin
                    n_status = ST_EMPTY;
                    n_state  = S_EMIT;
                end else begin
                    op = OP_SCAN_NEXT;
                end
            end
            S_KSETW: begin
                op      = OP_KSET;
                n_state = S_MUL;
            end
            S_MUL: begin
                op      = OP_MUL;
                n_state = S_AMT;
            end
            S_AMT: begin
                if (r_whole && !i_sts.k_is_cnt) begin
                    op      = OP_DIV_EVICT;
                    n_state = S_EDIV;
                end else begin
                    op      = r_whole ? OP_AMT_SUM : OP_AMT_PROD;
                    n_state = S_APPLY;
                end
            end
            S_EDIV: begin
                if (i_sts.div_done) begin
                    op      = OP_AMT_QUOT;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                op      = OP_APPLY;
                n_state = S_POP_RD;
            end
            S_POP_RD: begin
                op      = OP_POP_RD;
                n_state = S_POP_OUT;
            end
            S_POP_OUT: begin
                if (i_sts.out_free) begin
                    op      = OP_POP_OUT;
                    n_state = i_sts.pop_last ? S_IDLE : S_POP_RD;
                end
            end
            S_RDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_REFILL_OUT;
                end
            end
            S_REFILL_OUT: begin
                if (i_sts.out_free) begin
                    op      = OP_EMIT_REFILL;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    op      = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_whole  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_whole  <= n_whole;
            r_status <= n_status;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_cmd.op     = op;
    assign o_cmd.whole  = n_whole;
    assign o_cmd.status = r_status;

endmodule

// File: rtl/size_class_free_block_cache.sv
// ----------------------------------------------------------------------------
// size_class_free_block_cache
// Per-size-class LIFO cache of free block handles with byte accounting.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Refill runs the radix-2 divider on the
// byte room unless the class capacity is zero. Take, extract and eviction pop
// handles through a read state and an output state each, set by the registered
// read of the handle stack RAM; a partial whole-class eviction adds a divider
// pass for the proportional byte division, and a whole-class eviction of an
// empty current class first scans the classes for a non-empty one. Results sit
// in an output register, so a stalled consumer holds the controller only in its
// output states, for pops and for status and refill results alike.
// ----------------------------------------------------------------------------
module size_class_free_block_cache
    import scfbc_pkg::*;
#(
    parameter int CLASS_COUNT       = 16,
    parameter int CLASS_BLOCK_LIMIT = 32,
    parameter int TOTAL_BYTE_LIMIT  = 65536,
    parameter int REFILL_LIMIT      = 16,
    parameter int STACK_DEPTH       = 64,
    parameter int HANDLE_BITS       = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_class_index,
    input  logic [16:0] i_class_capacity,
    input  logic [31:0] i_handle,
    input  logic [6:0]  i_max_count,
    input  logic [6:0]  i_available_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_handle_out,
    output logic        o_handle_valid,
    output logic [3:0]  o_class_out,
    output logic [6:0]  o_accept_count,
    output logic        o_last,
    output logic [1:0]  o_status
);

    t_cmd cmd;
    t_sts sts;

    scfbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    scfbc_dp #(
        .CLASS_COUNT       (CLASS_COUNT),
        .CLASS_BLOCK_LIMIT (CLASS_BLOCK_LIMIT),
        .TOTAL_BYTE_LIMIT  (TOTAL_BYTE_LIMIT),
        .REFILL_LIMIT      (REFILL_LIMIT),
        .STACK_DEPTH       (STACK_DEPTH),
        .HANDLE_BITS       (HANDLE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_class_index     (i_class_index),
        .i_class_capacity  (i_class_capacity),
        .i_handle          (i_handle),
        .i_max_count       (i_max_count),
        .i_available_count (i_available_count),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_handle_out      (o_handle_out),
        .o_handle_valid    (o_handle_valid),
        .o_class_out       (o_class_out),
        .o_accept_count    (o_accept_count),
        .o_last            (o_last),
        .o_status          (o_status)
    );

    // a popped handle always carries ok status
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_handle_valid |-> o_status == ST_OK)
        else $error("popped handle with non-ok status");

    // status-only results are single
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_handle_valid |-> o_last)
        else $error("status result without last");

    // one transaction in flight
    a_one_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while busy");

    // a nonzero refill answer is ok
    a_refill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_accept_count != 7'd0) |-> o_status == ST_OK && !o_handle_valid)
        else $error("refill answer with bad status");

endmodule
